[hw/rtl/gmuf_pkg.sv]
// gmuf_pkg: shared constants for the grid maze union-find block.
// Beat layouts, wall direction codes and controller state codes.
// No dependencies.
package gmuf_pkg;

  // Stream beat widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Input field widths
  localparam int unsigned ROW_W = 4;
  localparam int unsigned COL_W = 4;
  localparam int unsigned DIR_W = 2;

  // Output field widths
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned REGION_W = 9;

  // Wall direction codes
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // Controller state codes
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_INIT = 3'd0;  // label memory clearing pass
  localparam logic [ST_W-1:0] ST_IDLE = 3'd1;  // waiting for an input beat
  localparam logic [ST_W-1:0] ST_RDF  = 3'd2;  // read label of chosen cell
  localparam logic [ST_W-1:0] ST_RDT  = 3'd3;  // read label of neighbor
  localparam logic [ST_W-1:0] ST_CMP  = 3'd4;  // compare the two labels
  localparam logic [ST_W-1:0] ST_SCAN = 3'd5;  // relabel sweep over all cells
  localparam logic [ST_W-1:0] ST_EMIT = 3'd6;  // load the output register

endpackage

[hw/rtl/grid_maze_union_find_top.sv]
// grid_maze_union_find_top: maze carving by Kruskal merging with a quick-find
// region label memory. Depends on gmuf_pkg (beat widths, state and direction codes).
//
// Usage:
//   Input stream (in_*): one beat names a cell (row, column) and a wall direction.
//   Output stream (out_*): exactly one beat per input beat, in order, reporting
//   whether the wall was broken, the two cell indices, the region count and a
//   completion flag.
//   Order: a beat that tries no merge (border, outside the grid, or maze
//   complete) goes straight to the emit state; one whose two cells already
//   share a region first passes two label reads and a compare; one that
//   merges two regions then runs the relabel sweep, which reads each label
//   entry once and rewrites those that hold the neighbor's label.
//   Throughput: one item at a time; in_tready is high only when no item is in
//   work, so a merging item occupies the block for its whole relabel sweep.
//   Reset: rst_n low clears control state; afterwards a clearing pass writes
//   every label with its own cell index, with in_tready low. The region count
//   restarts at WIDTH*HEIGHT.
//   Stall: the result sits in an output register; if out_tready stays low the
//   block still accepts one more beat and finishes it, then holds until the
//   output register is free.
module grid_maze_union_find_top #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned HEIGHT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: row [3:0], column [7:4], direction [9:8], zero [15:10]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gmuf_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata: wall_broken [0], cell_from [8:1], cell_to [16:9],
  //            regions_left [25:17], complete [26], zero [31:27]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gmuf_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned CELLS = WIDTH * HEIGHT;
  localparam int unsigned IDXW  = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned SW    = IDXW + 1;
  // Width that holds row*WIDTH+column for any 4-bit row and column
  localparam int unsigned FW    = $clog2(16 * WIDTH + 16);
  localparam int unsigned LW0   = (FW > IDXW) ? FW : IDXW;
  localparam int unsigned LW    = (LW0 > gmuf_pkg::CELL_W) ? LW0 : gmuf_pkg::CELL_W;
  localparam int unsigned CXW   = (CW > gmuf_pkg::REGION_W) ? CW : gmuf_pkg::REGION_W;
  localparam int unsigned PADW  = gmuf_pkg::OUT_DATA_W - 1 - 2 * gmuf_pkg::CELL_W
                                  - gmuf_pkg::REGION_W - 1;

  // Label memory: one read port with registered data, one write port
  logic [IDXW-1:0] lbl_mem [CELLS];
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [IDXW-1:0] mem_wdata;
  logic [IDXW-1:0] mem_raddr;
  logic [IDXW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= lbl_mem[mem_raddr];
  end

  // Control and payload registers
  logic [gmuf_pkg::ST_W-1:0] state_r, state_nxt;
  logic [SW-1:0]             scan_r, scan_nxt;
  logic                      pend_r, pend_nxt;
  logic [IDXW-1:0]           pend_addr_r, pend_addr_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [LW-1:0]             from_r, from_nxt;
  logic [LW-1:0]             to_r, to_nxt;
  logic                      broken_r, broken_nxt;
  logic [IDXW-1:0]           lf_r, lf_nxt;
  logic [IDXW-1:0]           lt_r, lt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [gmuf_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Input field decode
  logic [gmuf_pkg::ROW_W-1:0] in_row;
  logic [gmuf_pkg::COL_W-1:0] in_col;
  logic [gmuf_pkg::DIR_W-1:0] in_dir;
  logic [LW-1:0]              row_x, col_x, from_c, to_c;
  logic                       in_grid, nb_exists, do_merge;

  assign in_row = in_tdata[3:0];
  assign in_col = in_tdata[7:4];
  assign in_dir = in_tdata[9:8];
  assign row_x  = LW'(in_row);
  assign col_x  = LW'(in_col);
  assign from_c = LW'(row_x * LW'(WIDTH)) + col_x;
  assign in_grid = (row_x < LW'(HEIGHT)) && (col_x < LW'(WIDTH));

  // Neighbor index and existence
  always_comb begin
    nb_exists = 1'b0;
    to_c      = from_c;
    unique case (in_dir)
      gmuf_pkg::DIR_UP: begin
        nb_exists = (in_row != '0);
        to_c      = from_c - LW'(WIDTH);
      end
      gmuf_pkg::DIR_RIGHT: begin
        nb_exists = ((col_x + LW'(1)) < LW'(WIDTH));
        to_c      = from_c + LW'(1);
      end
      gmuf_pkg::DIR_DOWN: begin
        nb_exists = ((row_x + LW'(1)) < LW'(HEIGHT));
        to_c      = from_c + LW'(WIDTH);
      end
      gmuf_pkg::DIR_LEFT: begin
        nb_exists = (in_col != '0);
        to_c      = from_c - LW'(1);
      end
      default: begin
        nb_exists = 1'b0;
        to_c      = from_c;
      end
    endcase
  end

  assign do_merge = in_grid && nb_exists && (count_r > CW'(1));

  // Result beat built from the finished item
  logic [CXW-1:0] count_x;
  logic [gmuf_pkg::CELL_W-1:0] cell_to_c;
  assign count_x   = CXW'(count_r);
  assign cell_to_c = broken_r ? to_r[gmuf_pkg::CELL_W-1:0] : '0;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    count_nxt     = count_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    broken_nxt    = broken_r;
    lf_nxt        = lf_r;
    lt_nxt        = lt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = scan_r[IDXW-1:0];
    mem_wdata     = scan_r[IDXW-1:0];
    mem_raddr     = scan_r[IDXW-1:0];
    in_tready     = (state_r == gmuf_pkg::ST_IDLE);

    unique case (state_r)
      gmuf_pkg::ST_INIT: begin
        // write each label with its own index
        mem_we   = 1'b1;
        scan_nxt = scan_r + SW'(1);
        if (scan_r == SW'(CELLS - 1)) begin
          scan_nxt  = '0;
          state_nxt = gmuf_pkg::ST_IDLE;
        end
      end
      gmuf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          from_nxt   = from_c;
          to_nxt     = to_c;
          broken_nxt = 1'b0;
          state_nxt  = do_merge ? gmuf_pkg::ST_RDF : gmuf_pkg::ST_EMIT;
        end
      end
      gmuf_pkg::ST_RDF: begin
        mem_raddr = from_r[IDXW-1:0];
        state_nxt = gmuf_pkg::ST_RDT;
      end
      gmuf_pkg::ST_RDT: begin
        mem_raddr = to_r[IDXW-1:0];
        lf_nxt    = rd_data_r;
        state_nxt = gmuf_pkg::ST_CMP;
      end
      gmuf_pkg::ST_CMP: begin
        if (rd_data_r == lf_r) begin
          state_nxt = gmuf_pkg::ST_EMIT;
        end else begin
          lt_nxt    = rd_data_r;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = gmuf_pkg::ST_SCAN;
        end
      end
      gmuf_pkg::ST_SCAN: begin
        // read entry scan_r, rewrite the entry read in the previous cycle if it holds lt_r
        mem_waddr = pend_addr_r;
        mem_wdata = lf_r;
        mem_we    = pend_r && (rd_data_r == lt_r);
        if (scan_r < SW'(CELLS)) begin
          scan_nxt      = scan_r + SW'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_r[IDXW-1:0];
        end else begin
          pend_nxt   = 1'b0;
          scan_nxt   = '0;
          count_nxt  = count_r - CW'(1);
          broken_nxt = 1'b1;
          state_nxt  = gmuf_pkg::ST_EMIT;
        end
      end
      gmuf_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {PADW'(0),
                           (count_r == CW'(1)),
                           count_x[gmuf_pkg::REGION_W-1:0],
                           cell_to_c,
                           from_r[gmuf_pkg::CELL_W-1:0],
                           broken_r};
          state_nxt     = gmuf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gmuf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmuf_pkg::ST_INIT;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      count_r     <= CW'(CELLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    broken_r    <= broken_nxt;
    lf_r        <= lf_nxt;
    lt_r        <= lt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
